FILE: sv/canmbx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canmbx_pkg: shared types and constants of the CAN mailbox controller
// Register map, MCR and CS bit positions, mailbox codes and helper functions.
// ----------------------------------------------------------------------------
package canmbx_pkg;

  localparam int REG_WORDS = 1024;
  localparam int MAILBOXES = 32;
  localparam int AW        = $clog2(REG_WORDS);
  localparam int MBW       = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;

  // register word indexes (bus address field is 10 bits)
  localparam logic [9:0] W_MCR    = 10'd0;
  localparam logic [9:0] W_TIMER  = 10'd2;
  localparam logic [9:0] W_RXMG   = 10'd4;
  localparam logic [9:0] W_RX14   = 10'd5;
  localparam logic [9:0] W_RX15   = 10'd6;
  localparam logic [9:0] W_ESR1   = 10'd8;
  localparam logic [9:0] W_IMASK1 = 10'd10;
  localparam logic [9:0] W_IFLAG2 = 10'd11;
  localparam logic [9:0] W_IFLAG1 = 10'd12;
  localparam logic [9:0] W_IFLAG3 = 10'd29;
  localparam int         W_MB     = 32;
  localparam int         W_RXIMR  = 544;
  localparam int         RXIMR_WORDS = 96;

  localparam logic [31:0] MCR_MDIS    = 32'h8000_0000;
  localparam logic [31:0] MCR_FRZ     = 32'h4000_0000;
  localparam logic [31:0] MCR_HALT    = 32'h1000_0000;
  localparam logic [31:0] MCR_NOTRDY  = 32'h0800_0000;
  localparam logic [31:0] MCR_SOFTRST = 32'h0200_0000;
  localparam logic [31:0] MCR_FRZACK  = 32'h0100_0000;
  localparam logic [31:0] MCR_LPMACK  = 32'h0010_0000;
  localparam logic [31:0] MCR_IRMQ    = 32'h0001_0000;
  localparam logic [31:0] MCR_ACKS    = MCR_LPMACK | MCR_FRZACK | MCR_NOTRDY;
  localparam logic [31:0] MCR_RESET   = 32'h8910_001F;

  localparam logic [3:0] CODE_RX_FULL  = 4'h2;
  localparam logic [3:0] CODE_RX_EMPTY = 4'h4;
  localparam logic [3:0] CODE_TX_IDLE  = 4'h8;
  localparam logic [3:0] CODE_TX_ABORT = 4'h9;
  localparam logic [3:0] CODE_TX_DATA  = 4'hC;

  typedef enum logic [1:0] {
    K_READ  = 2'd0,
    K_WRITE = 2'd1,
    K_RX    = 2'd2,
    K_NOP   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [9:0]   addr;
    logic [31:0]  wdata;
    logic [28:0]  ident;
    logic         ext;
    logic         remote;
    logic [3:0]   len;
    logic [63:0]  payload;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        tx_valid;
    logic [28:0] tx_ident;
    logic        tx_extended;
    logic        tx_remote;
    logic [3:0]  tx_length;
    logic [63:0] tx_payload;
    logic        rx_stored;
  } result_t;

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [3:0] clamp_len(input logic [3:0] l);
    return (l > 4'd8) ? 4'd8 : l;
  endfunction

  // byte-enable mask for the first l bytes (l at most 8)
  function automatic logic [63:0] len_mask(input logic [3:0] l);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < l) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // recompute the three ack bits, SOFTRST self-clears
  function automatic logic [31:0] mcr_refresh(input logic [31:0] v);
    logic [31:0] m;
    m = v & ~(MCR_ACKS | MCR_SOFTRST);
    if ((v & MCR_MDIS) != '0) m = m | MCR_ACKS;
    else if (((v & MCR_FRZ) != '0) && ((v & MCR_HALT) != '0))
      m = m | MCR_FRZACK | MCR_NOTRDY;
    return m;
  endfunction

endpackage

FILE: sv/can_mailbox_controller.sv
`timescale 1ns / 1ps
// Path: register reads and writes go from idle straight to ST_DONE; memory-backed reads
//   pass ST_RD, write-one-to-clear words ST_W1C, a transmit ST_TX_RD0 and ST_TX_RD1; a
//   received frame scans up to 32 mailboxes via ST_SCAN_A/B/C, storing a hit via ST_ST_*.
// Flow: one item in the back end at a time; the next is taken from the front only in idle
//   and only after the result beat has been taken.
// Reset: async, active low; a clearing pass over all 1024 words loads the image before the
//   first item runs (the front still queues two beats). A soft reset through MCR runs it again.
// ----------------------------------------------------------------------------
// can_mailbox_controller: CAN controller with 32 message buffers
// Front end queues bus reads, bus writes and received frames; back end owns
// the register file, does the acceptance scan and builds transmit frames.
// ----------------------------------------------------------------------------
module can_mailbox_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: word_addr[9:0], write_data[31:0], rx_ident[28:0],
  // rx_extended, rx_remote, rx_length[3:0], rx_payload[63:0], 3 zero bits
  input  logic [143:0] s_axis_tdata_i,
  // tuser: func[1:0] (0 read, 1 write, 2 received frame)
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: read_data[31:0], irq_line, tx_valid, tx_ident[28:0],
  // tx_extended, tx_remote, tx_length[3:0], tx_payload[63:0], rx_stored, 2 zero bits
  output logic [135:0] m_axis_tdata_o
);
  import canmbx_pkg::*;

  item_t   item;
  logic    item_valid, item_pop;
  result_t res;

  // front: beat decode and two-entry queue, so the bus side can queue two beats during a scan
  canmbx_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .item_o          (item),
    .item_valid_o    (item_valid),
    .item_pop_i      (item_pop)
  );

  // back: sequencer over the register memory, result held in an output register
  canmbx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .result_o        (res)
  );

  assign m_axis_tdata_o = {2'b00, res.rx_stored, res.tx_payload, res.tx_length,
                           res.tx_remote, res.tx_extended, res.tx_ident,
                           res.tx_valid, res.irq_line, res.read_data};

endmodule

FILE: sv/canmbx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canmbx_front: input side of the CAN mailbox controller
// Accepts beats, decodes the selector and queues items two deep.
// ----------------------------------------------------------------------------
module canmbx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [143:0]        s_axis_tdata_i,
  input  logic [1:0]          s_axis_tuser_i,
  output canmbx_pkg::item_t   item_o,
  output logic                item_valid_o,
  input  logic                item_pop_i
);
  import canmbx_pkg::*;

  item_t      q_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  item_t      dec;
  logic       push, pop;

  always_comb begin
    dec.addr    = s_axis_tdata_i[9:0];
    dec.wdata   = s_axis_tdata_i[41:10];
    dec.ident   = s_axis_tdata_i[70:42];
    dec.ext     = s_axis_tdata_i[71];
    dec.remote  = s_axis_tdata_i[72];
    dec.len     = s_axis_tdata_i[76:73];
    dec.payload = s_axis_tdata_i[140:77];
    case (s_axis_tuser_i)
      2'd0:    dec.kind = K_READ;
      2'd1:    dec.kind = K_WRITE;
      2'd2:    dec.kind = K_RX;
      default: dec.kind = K_NOP;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign item_valid_o    = (cnt_q != 2'd0);
  assign item_o          = q_q[rd_q];
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/canmbx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canmbx_back: execution side of the CAN mailbox controller
// Register file, mailbox scan, transmit assembly and result register.
// ----------------------------------------------------------------------------
module canmbx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  canmbx_pkg::item_t   item_i,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output canmbx_pkg::result_t result_o
);
  import canmbx_pkg::*;

  typedef enum logic [13:0] {
    ST_CLEAR  = 14'h0001,
    ST_IDLE   = 14'h0002,
    ST_RD     = 14'h0004,
    ST_W1C    = 14'h0008,
    ST_TX_RD0 = 14'h0010,
    ST_TX_RD1 = 14'h0020,
    ST_SCAN_A = 14'h0040,
    ST_SCAN_B = 14'h0080,
    ST_SCAN_C = 14'h0100,
    ST_ST_D0  = 14'h0200,
    ST_ST_D1  = 14'h0400,
    ST_ST_ID  = 14'h0800,
    ST_ST_CS  = 14'h1000,
    ST_DONE   = 14'h2000
  } state_e;

  state_e         state_q, state_d;
  item_t          cur_q, cur_d;
  result_t        res_q, res_d, out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic [31:0]    mcr_q, mcr_d, rxmg_q, rxmg_d, rx14_q, rx14_d, rx15_q, rx15_d;
  logic [31:0]    imask1_q, imask1_d, iflag1_q, iflag1_d, stamp_q, stamp_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [MBW-1:0] mbx_q, mbx_d;
  logic [31:0]    cs_q, cs_d, id_q, id_d, d0_q, d0_d;
  logic           soft_q, soft_d;

  logic [31:0]    mem [REG_WORDS];
  logic           mem_we;
  logic [AW-1:0]  mem_wa, ra_a, ra_b;
  logic [31:0]    mem_wd, rd_a_q, rd_b_q;

  logic           running, in_range, is_cs, hit;
  logic [AW-1:0]  mb_base;
  logic [9:0]     rel_addr;
  logic [31:0]    mask, mstd, cs_w;
  logic [3:0]     len;
  logic [63:0]    paym;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_a_q <= mem[ra_a];
    rd_b_q <= mem[ra_b];
  end

  assign running  = ((mcr_q & (MCR_MDIS | MCR_FRZACK)) == '0);
  assign in_range = (32'(item_i.addr) < REG_WORDS);
  assign rel_addr = item_i.addr - 10'(W_MB);
  assign is_cs    = (32'(item_i.addr) >= W_MB) &&
                    (32'(item_i.addr) < W_MB + 4 * MAILBOXES) && (item_i.addr[1:0] == 2'b00);
  assign mb_base  = AW'(W_MB) + AW'({mbx_q, 2'b00});
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i && !out_valid_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mcr_d       = mcr_q;
    rxmg_d      = rxmg_q;
    rx14_d      = rx14_q;
    rx15_d      = rx15_q;
    imask1_d    = imask1_q;
    iflag1_d    = iflag1_q;
    stamp_d     = stamp_q;
    clr_d       = clr_q;
    mbx_d       = mbx_q;
    cs_d        = cs_q;
    id_d        = id_q;
    d0_d        = d0_q;
    soft_d      = soft_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    ra_a        = '0;
    ra_b        = '0;
    mask        = rxmg_q;
    mstd        = '0;
    hit         = 1'b0;
    cs_w        = '0;
    len         = clamp_len(cur_q.len);
    paym        = cur_q.payload & len_mask(clamp_len(cur_q.len));

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = ((32'(clr_q) >= W_RXIMR) && (32'(clr_q) < W_RXIMR + RXIMR_WORDS)) ?
                 32'hFFFF_FFFF : 32'h0;
        clr_d  = clr_q + 1'b1;
        if (32'(clr_q) == REG_WORDS - 1) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_pop_o) begin
          cur_d   = item_i;
          res_d   = '0;
          soft_d  = 1'b0;
          state_d = ST_DONE;
          case (item_i.kind)
            K_READ: begin
              if (in_range) begin
                if (item_i.addr == W_TIMER) begin
                  res_d.read_data = stamp_q;
                  stamp_d = stamp_q + 32'd1;
                end else if (item_i.addr inside {W_MCR, W_RXMG, W_RX14, W_RX15,
                                                 W_IMASK1, W_IFLAG1}) begin
                  case (item_i.addr)
                    W_MCR:    res_d.read_data = mcr_q;
                    W_RXMG:   res_d.read_data = rxmg_q;
                    W_RX14:   res_d.read_data = rx14_q;
                    W_RX15:   res_d.read_data = rx15_q;
                    W_IMASK1: res_d.read_data = imask1_q;
                    default:  res_d.read_data = iflag1_q;
                  endcase
                end else begin
                  ra_a    = AW'(item_i.addr);
                  state_d = ST_RD;
                end
              end
            end
            K_WRITE: begin
              if (in_range) begin
                case (item_i.addr)
                  W_MCR: begin
                    if ((item_i.wdata & MCR_SOFTRST) != '0) begin
                      mcr_d    = MCR_RESET;
                      rxmg_d   = '1;
                      rx14_d   = '1;
                      rx15_d   = '1;
                      imask1_d = '0;
                      iflag1_d = '0;
                      stamp_d  = '0;
                      soft_d   = 1'b1;
                    end else begin
                      mcr_d = mcr_refresh((mcr_q & MCR_ACKS) | (item_i.wdata & ~MCR_ACKS));
                    end
                  end
                  W_RXMG:   rxmg_d   = item_i.wdata;
                  W_RX14:   rx14_d   = item_i.wdata;
                  W_RX15:   rx15_d   = item_i.wdata;
                  W_IMASK1: imask1_d = item_i.wdata;
                  W_IFLAG1: iflag1_d = iflag1_q & ~item_i.wdata;
                  W_IFLAG2, W_IFLAG3, W_ESR1: begin
                    ra_a    = AW'(item_i.addr);
                    state_d = ST_W1C;
                  end
                  default: begin
                    mem_we = 1'b1;
                    mem_wa = AW'(item_i.addr);
                    mem_wd = item_i.wdata;
                    if (is_cs && running) begin
                      mbx_d = rel_addr[MBW+1:2];
                      if (item_i.wdata[27:24] == CODE_TX_ABORT) begin
                        // abort is only acknowledged: fresh stamp and flag
                        mem_wd   = {item_i.wdata[31:28], CODE_TX_ABORT,
                                    item_i.wdata[23:16], stamp_q[15:0]};
                        iflag1_d = iflag1_q | (32'd1 << rel_addr[MBW+1:2]);
                        stamp_d  = stamp_q + 32'd1;
                      end else if (item_i.wdata[27:24] == CODE_TX_DATA) begin
                        ra_a    = AW'(item_i.addr) + AW'(1);
                        ra_b    = AW'(item_i.addr) + AW'(2);
                        state_d = ST_TX_RD0;
                      end
                    end
                  end
                endcase
              end
            end
            K_RX: begin
              if (running) begin
                mbx_d   = '0;
                state_d = ST_SCAN_A;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        res_d.read_data = rd_a_q;
        state_d = ST_DONE;
      end
      ST_W1C: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(cur_q.addr);
        mem_wd  = rd_a_q & ~cur_q.wdata;
        state_d = ST_DONE;
      end
      ST_TX_RD0: begin
        id_d    = rd_a_q;
        d0_d    = rd_b_q;
        ra_a    = mb_base + AW'(3);
        state_d = ST_TX_RD1;
      end
      ST_TX_RD1: begin
        len = clamp_len(cur_q.wdata[19:16]);
        res_d.tx_valid    = 1'b1;
        res_d.tx_extended = cur_q.wdata[21];
        res_d.tx_ident    = cur_q.wdata[21] ? id_q[28:0] : {18'd0, id_q[28:18]};
        res_d.tx_remote   = cur_q.wdata[20];
        res_d.tx_length   = len;
        res_d.tx_payload  = {bswap32(rd_a_q), bswap32(d0_q)} & len_mask(len);
        mem_we   = 1'b1;
        mem_wa   = mb_base;
        mem_wd   = {cur_q.wdata[31:28], CODE_TX_IDLE, cur_q.wdata[23:16], stamp_q[15:0]};
        iflag1_d = iflag1_q | (32'd1 << mbx_q);
        stamp_d  = stamp_q + 32'd1;
        state_d  = ST_DONE;
      end
      ST_SCAN_A: begin
        ra_a    = mb_base;
        ra_b    = mb_base + AW'(1);
        state_d = ST_SCAN_B;
      end
      ST_SCAN_B: begin
        cs_d    = rd_a_q;
        id_d    = rd_b_q;
        ra_a    = AW'(W_RXIMR) + AW'(mbx_q);
        state_d = ST_SCAN_C;
      end
      ST_SCAN_C: begin
        if ((mcr_q & MCR_IRMQ) != '0)    mask = rd_a_q;
        else if (32'(mbx_q) == 14)       mask = rx14_q;
        else if (32'(mbx_q) == 15)       mask = rx15_q;
        else                             mask = rxmg_q;
        mstd = {21'd0, mask[28:18]};
        if (cs_q[27:24] == CODE_RX_EMPTY && cs_q[21] == cur_q.ext) begin
          if (cur_q.ext)
            hit = ((id_q[28:0] & mask[28:0]) == (cur_q.ident & mask[28:0]));
          else
            hit = ((id_q[28:18] & mstd[10:0]) == (cur_q.ident[10:0] & mstd[10:0]));
        end
        if (hit)                                 state_d = ST_ST_D0;
        else if (32'(mbx_q) == MAILBOXES - 1)    state_d = ST_DONE;
        else begin
          mbx_d   = mbx_q + 1'b1;
          state_d = ST_SCAN_A;
        end
      end
      ST_ST_D0: begin
        mem_we  = 1'b1;
        mem_wa  = mb_base + AW'(2);
        mem_wd  = bswap32(paym[31:0]);
        state_d = ST_ST_D1;
      end
      ST_ST_D1: begin
        mem_we  = 1'b1;
        mem_wa  = mb_base + AW'(3);
        mem_wd  = bswap32(paym[63:32]);
        state_d = ST_ST_ID;
      end
      ST_ST_ID: begin
        mem_we  = 1'b1;
        mem_wa  = mb_base + AW'(1);
        mem_wd  = cur_q.ext ? {3'd0, cur_q.ident} : {3'd0, cur_q.ident[10:0], 18'd0};
        state_d = ST_ST_CS;
      end
      ST_ST_CS: begin
        cs_w     = {4'd0, CODE_RX_FULL, 2'd0, cur_q.ext, cur_q.remote, len, stamp_q[15:0]};
        mem_we   = 1'b1;
        mem_wa   = mb_base;
        mem_wd   = cs_w;
        iflag1_d = iflag1_q | (32'd1 << mbx_q);
        stamp_d  = stamp_q + 32'd1;
        res_d.rx_stored = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        out_d          = res_q;
        out_d.irq_line = ((iflag1_q & imask1_q) != '0);
        out_valid_d    = 1'b1;
        state_d        = soft_q ? ST_CLEAR : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    out_q <= out_d;
    cs_q  <= cs_d;
    id_q  <= id_d;
    d0_q  <= d0_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      mcr_q       <= MCR_RESET;
      rxmg_q      <= '1;
      rx14_q      <= '1;
      rx15_q      <= '1;
      imask1_q    <= '0;
      iflag1_q    <= '0;
      stamp_q     <= '0;
      clr_q       <= '0;
      mbx_q       <= '0;
      soft_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      mcr_q       <= mcr_d;
      rxmg_q      <= rxmg_d;
      rx14_q      <= rx14_d;
      rx15_q      <= rx15_d;
      imask1_q    <= imask1_d;
      iflag1_q    <= iflag1_d;
      stamp_q     <= stamp_d;
      clr_q       <= clr_d;
      mbx_q       <= mbx_d;
      soft_q      <= soft_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign result_o        = out_q;

endmodule

FILE: sv/canmbx_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canmbx_chk: port checker for the CAN mailbox controller
// Watches the result stream for handshake and field consistency.
// ----------------------------------------------------------------------------
module canmbx_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [135:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_tx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[33] |-> m_axis_tdata_o[132:34] == '0)
    else $error("transmit fields set without a frame");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[33] && m_axis_tdata_o[133]))
    else $error("transmit and receive on one beat");

  a_txlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33] |->
      m_axis_tdata_o[68:65] <= 4'd8 && m_axis_tdata_o[31:0] == '0)
    else $error("bad transmit beat");

endmodule

bind can_mailbox_controller canmbx_chk u_canmbx_chk (.*);
